### sv/qte_pkg.sv
// Shared types, widths and constants for the quaternion to Euler angle core.
// Used by the square-root cells, the CORDIC cells and the top level.
`default_nettype none
package qte_pkg;

    localparam int T_W        = 34;  // t terms at Q6.28
    localparam int S_W        = 30;  // clamped pitch term, +-2^28
    localparam int V_W        = 58;  // square-root remainder and root
    localparam int CX_W       = 40;  // CORDIC x and y
    localparam int CZ_W       = 34;  // CORDIC angle accumulator, pi/2^31 units
    localparam int ANG_W      = 16;  // binary angle output
    localparam int ATAN_LEN   = 24;
    localparam int SQRT_STEPS = 29;  // root bits for a 57-bit radicand

    localparam logic signed [CZ_W-1:0] Z_QUARTER = 34'sh0_4000_0000;

    localparam logic [29:0] ATAN_TAB [ATAN_LEN] = '{
        30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4,
        30'h028B0D43, 30'h0145D7E1, 30'h00A2F61E, 30'h00517C55,
        30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
        30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D,
        30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
        30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051
    };

    typedef struct packed {
        logic [V_W-1:0]         v;
        logic [V_W-1:0]         res;
        logic signed [T_W-1:0]  t0;
        logic signed [T_W-1:0]  t1;
        logic signed [T_W-1:0]  t3;
        logic signed [T_W-1:0]  t4;
        logic signed [S_W-1:0]  s;
        logic                   clamped;
    } t_sqrt_data;

    typedef struct packed {
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [CZ_W-1:0] z;
        logic                   zero;
    } t_cord_data;

    typedef struct packed {
        logic signed [ANG_W-1:0] pitch;
        logic signed [ANG_W-1:0] roll;
        logic signed [ANG_W-1:0] yaw;
        logic                    clamped;
    } t_result;

    // Turn a left-half-plane vector by a quarter turn and preset the angle.
    function automatic t_cord_data prerot(input logic signed [CX_W-1:0] y,
                                          input logic signed [CX_W-1:0] x);
        t_cord_data r;
        r.zero = (x == '0) && (y == '0);
        r.x    = x;
        r.y    = y;
        r.z    = '0;
        if (x < 0) begin
            if (y >= 0) begin
                r.x = y;
                r.y = -x;
                r.z = Z_QUARTER;
            end else begin
                r.x = -y;
                r.y = x;
                r.z = -Z_QUARTER;
            end
        end
        return r;
    endfunction

    // Round the accumulator to a 16-bit binary angle, wrapping modulo 2^16.
    function automatic logic signed [ANG_W-1:0] to_bam(input t_cord_data c);
        logic signed [CZ_W-1:0] rz;
        rz = c.z + CZ_W'(32768);
        return c.zero ? '0 : rz[31:16];
    endfunction

endpackage
`default_nettype wire

### sv/qte_sqrt_cell.sv
// One digit cell of the restoring integer square root chain.
// Depends on qte_pkg for t_sqrt_data.
`default_nettype none
module qte_sqrt_cell
    import qte_pkg::*;
#(
    parameter int K = 0
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic       i_valid,
    input  wire t_sqrt_data i_data,
    output logic            o_valid,
    output t_sqrt_data      o_data
);
    localparam logic [V_W-1:0] BIT = V_W'(1) << (2 * (SQRT_STEPS - 1 - K));

    logic            r_valid;
    t_sqrt_data      r_data;
    t_sqrt_data      n_data;
    logic [V_W-1:0]  sum;

    // Try one root bit against the remainder
    always_comb begin
        n_data = i_data;
        sum    = i_data.res + BIT;
        if (i_data.v >= sum) begin
            n_data.v   = i_data.v - sum;
            n_data.res = (i_data.res >> 1) + BIT;
        end else begin
            n_data.res = i_data.res >> 1;
        end
    end

    // Advance valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Hold payload while stalled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule
`default_nettype wire

### sv/qte_cordic_cell.sv
// One micro-rotation cell of the vectoring CORDIC chain.
// Depends on qte_pkg for t_cord_data and the arctangent table.
`default_nettype none
module qte_cordic_cell
    import qte_pkg::*;
#(
    parameter int I = 0
) (
    input  wire logic       i_clk,
    input  wire logic       i_en,
    input  wire t_cord_data i_data,
    output t_cord_data      o_data
);
    t_cord_data             r_data;
    t_cord_data             n_data;
    logic signed [CX_W-1:0] dx;
    logic signed [CX_W-1:0] dy;
    logic signed [CZ_W-1:0] ang;

    // Rotate toward the x axis by atan(2^-I)
    always_comb begin
        dx     = i_data.y >>> I;
        dy     = i_data.x >>> I;
        ang    = CZ_W'(ATAN_TAB[I]);
        n_data = i_data;
        if (i_data.y > 0) begin
            n_data.x = i_data.x + dx;
            n_data.y = i_data.y - dy;
            n_data.z = i_data.z + ang;
        end else begin
            n_data.x = i_data.x - dx;
            n_data.y = i_data.y + dy;
            n_data.z = i_data.z - ang;
        end
    end

    // Hold payload while stalled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;
endmodule
`default_nettype wire

### sv/quaternion_to_euler_angles_core.sv
// Quaternion to Euler angles: products, sums, a 29-cell square-root chain and
// three CORDIC_STAGES-cell CORDIC chains, ending in the output register;
// throughput one item per cycle while the skid entry is empty, set by the
// cell chains moving one step per cycle. A two-entry output (register plus
// skid) freezes the chains only when both entries are full.
// Synchronous active-low reset clears all valid bits; payload is not reset.
`default_nettype none
module quaternion_to_euler_angles_core
    import qte_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic signed [15:0] i_quat_w,
    input  wire logic signed [15:0] i_quat_x,
    input  wire logic signed [15:0] i_quat_y,
    input  wire logic signed [15:0] i_quat_z,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic signed [15:0]     o_pitch_angle,
    output logic signed [15:0]     o_roll_angle,
    output logic signed [15:0]     o_yaw_angle,
    output logic                   o_pitch_clamped
);
    localparam int N = CORDIC_STAGES;
    localparam logic signed [35:0] UNIT = 36'sd268435456;
    localparam logic [V_W-1:0] RAD_TOP = V_W'(1) << 56;

    logic en;

    // ---------------- stage 1: products
    logic                r1_v;
    logic signed [31:0]  r_xy, r_wz, r_xz, r_wy, r_yz, r_wx, r_xx, r_yy, r_zz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xy <= 32'(i_quat_x) * 32'(i_quat_y);
            r_wz <= 32'(i_quat_w) * 32'(i_quat_z);
            r_xz <= 32'(i_quat_x) * 32'(i_quat_z);
            r_wy <= 32'(i_quat_w) * 32'(i_quat_y);
            r_yz <= 32'(i_quat_y) * 32'(i_quat_z);
            r_wx <= 32'(i_quat_w) * 32'(i_quat_x);
            r_xx <= 32'(i_quat_x) * 32'(i_quat_x);
            r_yy <= 32'(i_quat_y) * 32'(i_quat_y);
            r_zz <= 32'(i_quat_z) * 32'(i_quat_z);
        end
    end

    // ---------------- stage 2: t terms and pitch clamp
    logic signed [35:0]    a0, a1, a2, a3, a4;
    logic signed [S_W-1:0] n_s;
    logic                  n_clamped;
    logic                  r2_v;
    logic signed [T_W-1:0] r2_t0, r2_t1, r2_t3, r2_t4;
    logic signed [S_W-1:0] r2_s;
    logic                  r2_clamped;

    always_comb begin
        a0 = UNIT - ((36'(r_yy) + 36'(r_zz)) <<< 1);
        a1 = (36'(r_xy) + 36'(r_wz)) <<< 1;
        a2 = (36'(r_wy) - 36'(r_xz)) <<< 1;
        a3 = (36'(r_yz) + 36'(r_wx)) <<< 1;
        a4 = UNIT - ((36'(r_xx) + 36'(r_yy)) <<< 1);
        n_clamped = 1'b0;
        n_s       = S_W'(a2);
        if (a2 > UNIT) begin
            n_s       = S_W'(UNIT);
            n_clamped = 1'b1;
        end else if (a2 < -UNIT) begin
            n_s       = S_W'(-UNIT);
            n_clamped = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_t0      <= T_W'(a0);
            r2_t1      <= T_W'(a1);
            r2_t3      <= T_W'(a3);
            r2_t4      <= T_W'(a4);
            r2_s       <= n_s;
            r2_clamped <= n_clamped;
        end
    end

    // ---------------- stage 3: square of the pitch term
    logic [28:0]     mag;
    logic [V_W-1:0]  sq;
    logic            r3_v;
    logic [V_W-1:0]  r3_sq;
    t_sqrt_data      r3_d;

    assign mag = (r2_s < 0) ? 29'(-r2_s) : 29'(r2_s);
    assign sq  = {29'd0, mag} * {29'd0, mag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_sq        <= sq;
            r3_d.v       <= '0;
            r3_d.res     <= '0;
            r3_d.t0      <= r2_t0;
            r3_d.t1      <= r2_t1;
            r3_d.t3      <= r2_t3;
            r3_d.t4      <= r2_t4;
            r3_d.s       <= r2_s;
            r3_d.clamped <= r2_clamped;
        end
    end

    // ---------------- square-root chain
    logic       w_sv [SQRT_STEPS+1];
    t_sqrt_data w_sd [SQRT_STEPS+1];

    always_comb begin
        w_sd[0]   = r3_d;
        w_sd[0].v = RAD_TOP - r3_sq;
    end
    assign w_sv[0] = r3_v;

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        qte_sqrt_cell #(.K(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_sv[k]),
            .i_data  (w_sd[k]),
            .o_valid (w_sv[k+1]),
            .o_data  (w_sd[k+1])
        );
    end

    // ---------------- pre-rotation of the three vectors
    t_sqrt_data sd;
    logic       r4_v;
    logic       r4_clamped;
    t_cord_data r4_c [3];

    assign sd = w_sd[SQRT_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= w_sv[SQRT_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_c[0]    <= prerot(CX_W'(sd.s), CX_W'(sd.res[28:0]));
            r4_c[1]    <= prerot(CX_W'(sd.t3), CX_W'(sd.t4));
            r4_c[2]    <= prerot(CX_W'(sd.t1), CX_W'(sd.t0));
            r4_clamped <= sd.clamped;
        end
    end

    // ---------------- CORDIC chains: pitch, roll, yaw lanes
    t_cord_data w_c [3][N+1];
    logic       r_cv [N];
    logic       r_cc [N];

    for (genvar l = 0; l < 3; l++) begin : g_lane
        assign w_c[l][0] = r4_c[l];
        for (genvar i = 0; i < N; i++) begin : g_stage
            qte_cordic_cell #(.I(i)) u_cell (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_data (w_c[l][i]),
                .o_data (w_c[l][i+1])
            );
        end
    end

    // Advance valid and clamp flag alongside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                r_cv[i] <= 1'b0;
            end
        end else if (en) begin
            r_cv[0] <= r4_v;
            for (int i = 1; i < N; i++) begin
                r_cv[i] <= r_cv[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cc[0] <= r4_clamped;
            for (int i = 1; i < N; i++) begin
                r_cc[i] <= r_cc[i-1];
            end
        end
    end

    // ---------------- output register and skid entry
    t_result pd;
    logic    pv;
    logic    take;
    logic    r_out_v;
    logic    r_hold_v;
    t_result r_out;
    t_result r_hold;

    assign pv         = r_cv[N-1];
    assign pd.pitch   = to_bam(w_c[0][N]);
    assign pd.roll    = to_bam(w_c[1][N]);
    assign pd.yaw     = to_bam(w_c[2][N]);
    assign pd.clamped = r_cc[N-1];

    assign en   = !r_hold_v;
    assign take = r_out_v && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_hold_v <= 1'b0;
        end else if (r_hold_v) begin
            if (take) begin
                r_hold_v <= 1'b0;
            end
        end else if (pv) begin
            if (r_out_v && !take) begin
                r_hold_v <= 1'b1;
            end else begin
                r_out_v <= 1'b1;
            end
        end else if (take) begin
            r_out_v <= 1'b0;
        end
    end

    // Load output from skid or chain end
    always_ff @(posedge i_clk) begin
        if (r_hold_v) begin
            if (take) begin
                r_out <= r_hold;
            end
        end else if (pv) begin
            if (r_out_v && !take) begin
                r_hold <= pd;
            end else begin
                r_out <= pd;
            end
        end
    end

    assign o_stall         = r_hold_v;
    assign o_valid         = r_out_v;
    assign o_pitch_angle   = r_out.pitch;
    assign o_roll_angle    = r_out.roll;
    assign o_yaw_angle     = r_out.yaw;
    assign o_pitch_clamped = r_out.clamped;

`ifndef SYNTHESIS
    a_hold_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_v |-> r_out_v)
        else $error("skid entry full while output register empty");

    a_hold_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hold_v && !i_stall) |=> (r_out_v && !r_hold_v))
        else $error("skid entry did not move to output");

    a_frozen_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_v |=> $stable(r_cv[N-1]))
        else $error("chain moved while skid entry full");
`endif
endmodule
`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for quaternion_to_euler_angles_core: predicts the three
// binary angles and the clamp flag for each item and checks every output item.
// Depends on qte_pkg (CORDIC arctangent table) and the core RTL.
`default_nettype none
module tb_top;
    import qte_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES     = 16;
    localparam int N_ITEMS    = 1550;
    localparam int QUIET_TAIL = 300;
    localparam int HOLD_AT    = 600;
    localparam int HOLD_LEN   = 200;
    localparam int DRAIN      = STAGES + 60;
    localparam longint UNIT   = 64'sd1 << 28;
    localparam int NO_FLAG    = -1;

    typedef struct {
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
        logic signed [15:0] yaw;
        logic               clamped;
    } t_euler;

    typedef struct {
        logic signed [15:0] w, x, y, z;
        int                 flag;  // known clamp flag, or NO_FLAG
    } t_quat_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic signed [15:0] i_quat_w = '0, i_quat_x = '0, i_quat_y = '0, i_quat_z = '0;
    logic o_stall, o_valid, o_pitch_clamped;
    logic signed [15:0] o_pitch_angle, o_roll_angle, o_yaw_angle;

    t_euler angles_due[$];
    int     n_errors = 0;
    bit     quiet = 1'b0;
    bit     hold_req = 1'b0;
    bit     in_done = 1'b0;

    quaternion_to_euler_angles_core #(.CORDIC_STAGES(STAGES)) dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Exact integer square root, one result bit per pass.
    function automatic longint int_sqrt(input longint unsigned v);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    // Vectoring CORDIC arctangent, rounded to a 16-bit binary angle.
    function automatic logic signed [15:0] cordic_angle(input longint yy, input longint xx);
        longint acc, dx, dy, tmp;
        if (xx == 0 && yy == 0) return '0;
        acc = 0;
        if (xx < 0) begin
            tmp = xx;
            if (yy >= 0) begin
                xx = yy; yy = -tmp; acc = 64'sd1 << 30;
            end else begin
                xx = -yy; yy = tmp; acc = -(64'sd1 << 30);
            end
        end
        for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
            dx = yy >>> i;
            dy = xx >>> i;
            if (yy > 0) begin
                xx += dx; yy -= dy; acc += longint'(ATAN_TAB[i]);
            end else begin
                xx -= dx; yy += dy; acc -= longint'(ATAN_TAB[i]);
            end
        end
        acc = (acc + 32768) >>> 16;
        return acc[15:0];
    endfunction

    function automatic t_euler euler_of(input logic signed [15:0] qw, qx, qy, qz);
        longint w, x, y, z, ysq, t0, t1, t2, t3, t4;
        t_euler e;
        w = qw; x = qx; y = qy; z = qz;
        ysq = y * y;
        t0 = UNIT - 2 * (ysq + z * z);
        t1 = 2 * (x * y + w * z);
        t2 = -2 * (x * z - w * y);
        t3 = 2 * (y * z + w * x);
        t4 = UNIT - 2 * (x * x + ysq);
        e.clamped = 1'b0;
        if (t2 > UNIT) begin
            t2 = UNIT; e.clamped = 1'b1;
        end else if (t2 < -UNIT) begin
            t2 = -UNIT; e.clamped = 1'b1;
        end
        e.pitch = cordic_angle(t2, int_sqrt(longint'(UNIT * UNIT - t2 * t2)));
        e.roll  = cordic_angle(t3, t4);
        e.yaw   = cordic_angle(t1, t0);
        return e;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // Offer one item at the falling edge and hold it until accepted.
    task automatic send_quat(input logic signed [15:0] qw, qx, qy, qz, input int flag);
        t_euler e;
        e = euler_of(qw, qx, qy, qz);
        if (flag != NO_FLAG && e.clamped != flag[0])
            report_mismatch("clamp flag of directed item", e.clamped, flag);
        @(negedge i_clk);
        i_valid  <= 1'b1;
        i_quat_w <= qw; i_quat_x <= qx; i_quat_y <= qy; i_quat_z <= qz;
        do @(posedge i_clk); while (o_stall);
        angles_due.push_back(e);
    endtask

    task automatic sender_gap();
        int n;
        if (quiet || $urandom_range(0, 3) != 0) return;
        n = $urandom_range(1, 9);
        @(negedge i_clk);
        i_valid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_part();
        case ($urandom_range(0, 9))
            0:       return 16'(16384);
            1:       return -16'sd16384;
            2:       return '0;
            3, 4:    return 16'($urandom());
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // Receiver: random stall bursts, one long hold, then steady acceptance.
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                for (int c = 0; c < HOLD_LEN; c++) @(negedge i_clk);
                hold_req = 1'b0;
                i_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 9);
                i_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Check each accepted output item against the oldest prediction.
    always @(posedge i_clk) begin
        t_euler e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (angles_due.size() == 0) begin
                report_mismatch("unexpected item, queue depth", 0, 0);
            end else begin
                e = angles_due.pop_front();
                if (o_pitch_angle !== e.pitch) report_mismatch("pitch", o_pitch_angle, e.pitch);
                if (o_roll_angle !== e.roll) report_mismatch("roll", o_roll_angle, e.roll);
                if (o_yaw_angle !== e.yaw) report_mismatch("yaw", o_yaw_angle, e.yaw);
                if (o_pitch_clamped !== e.clamped)
                    report_mismatch("pitch_clamped", o_pitch_clamped, e.clamped);
            end
        end
    end

    // Directed rows: identity, zero, extremes, both clamps, left-half-plane
    // vectors for roll and yaw, and an exact half turn that wraps to -32768.
    t_quat_row directed[] = '{
        '{16384, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0},
        '{-16384, 0, 0, 0, 0},
        '{-32768, -32768, -32768, -32768, NO_FLAG},
        '{32767, 32767, 32767, 32767, NO_FLAG},
        '{-32768, 32767, -32768, 32767, NO_FLAG},
        '{16384, 0, 16384, 0, 1},
        '{16384, 0, -16384, 0, 1},
        '{11585, 0, 11585, 0, 0},
        '{11585, 0, -11585, 0, 0},
        '{0, 16384, 0, 0, 0},
        '{0, 0, 0, 16384, 0},
        '{0, 0, 16384, 0, 0},
        '{16384, -16384, 0, 0, 0},
        '{-16384, 0, 0, 16384, 0},
        '{8192, 8192, 8192, 8192, 0},
        '{8192, -8192, 8192, -8192, NO_FLAG},
        '{1, -1, 1, -1, 0},
        '{0, 0, 0, -32768, 0},
        '{-32768, 0, 0, 0, 0}
    };

    // Stimulus: reset, directed rows, then random quaternions.
    initial begin
        int limit;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed[k])
            send_quat(directed[k].w, directed[k].x, directed[k].y, directed[k].z,
                      directed[k].flag);
        for (int k = directed.size(); k < N_ITEMS; k++) begin
            if (k == HOLD_AT) hold_req = 1'b1;
            if (k == N_ITEMS - QUIET_TAIL) quiet = 1'b1;
            sender_gap();
            send_quat(rand_part(), rand_part(), rand_part(), rand_part(), NO_FLAG);
        end
        @(negedge i_clk);
        i_valid <= 1'b0;
        limit = 0;
        while (angles_due.size() != 0 && limit < 10000) begin
            @(posedge i_clk);
            limit++;
        end
        repeat (DRAIN) @(posedge i_clk);
        if (n_errors == 0 && angles_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire

### files.f
sv/qte_pkg.sv
sv/qte_sqrt_cell.sv
sv/qte_cordic_cell.sv
sv/quaternion_to_euler_angles_core.sv
bench/tb_top.sv
